// ===== rtl/core/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared sizes, types and helpers for the LFU page replacement unit.
// ----------------------------------------------------------------------------
package lfu_pkg;

    // Build-time sizes
    localparam int FRAMES     = 8;
    localparam int PAGE_BITS  = 16;
    localparam int COUNT_BITS = 16;

    // Derived widths
    localparam int IDX_BITS      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FILL_BITS     = $clog2(FRAMES + 1);
    localparam int CFG_BITS      = 4;
    localparam int OUT_IDX_BITS  = 3;
    localparam int OUT_PAGE_BITS = 16;
    localparam int FAULT_BITS    = 16;
    localparam int IN_PAGE_BITS  = 16;
    localparam int CFG_RESET     = 8;

    typedef logic [PAGE_BITS-1:0]  page_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [IDX_BITS-1:0]   frame_idx_t;
    typedef logic [FILL_BITS-1:0]  fill_t;

    localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam count_t COUNT_ONE = count_t'(1);

    // Outcome of one reference, from the frame table to the top level
    typedef struct packed {
        logic       hit;
        logic       evict;
        frame_idx_t slot;
        page_t      old_page;
    } lfu_decision_t;

    // Clamp the programmed frame count into 1 .. FRAMES
    function automatic fill_t lfu_active(input logic [CFG_BITS-1:0] num);
        fill_t res;
        if (num == '0)
            res = fill_t'(1);
        else if (int'(num) > FRAMES)
            res = fill_t'(FRAMES);
        else
            res = fill_t'(num);
        return res;
    endfunction

endpackage

// ===== rtl/core/lfu_victim_select.sv =====
// ----------------------------------------------------------------------------
// lfu_victim_select
// Compare tree that finds the eligible frame with the smallest use count,
// ties resolved toward the lowest frame index.
// ----------------------------------------------------------------------------
module lfu_victim_select
    import lfu_pkg::*;
(
    input  count_t            counts [FRAMES],
    input  logic [FRAMES-1:0] eligible,
    output frame_idx_t        victim
);

    localparam int LEVELS = IDX_BITS;
    localparam int LEAVES = 1 << IDX_BITS;

    count_t     node_cnt [LEVELS+1][LEAVES];
    frame_idx_t node_idx [LEVELS+1][LEAVES];
    logic       node_ok  [LEVELS+1][LEAVES];

    // Reduce pairs level by level; the left node wins on equal counts
    always_comb
    begin
        for (int l = 0; l <= LEVELS; l++)
        begin
            for (int j = 0; j < LEAVES; j++)
            begin
                node_cnt[l][j] = '0;
                node_idx[l][j] = '0;
                node_ok[l][j]  = 1'b0;
            end
        end
        for (int j = 0; j < LEAVES; j++)
        begin
            if (j < FRAMES)
            begin
                node_cnt[0][j] = counts[j];
                node_idx[0][j] = frame_idx_t'(j);
                node_ok[0][j]  = eligible[j];
            end
        end
        for (int l = 0; l < LEVELS; l++)
        begin
            for (int j = 0; j < (LEAVES >> (l + 1)); j++)
            begin
                if (node_ok[l][2*j] &&
                    (!node_ok[l][2*j+1] || node_cnt[l][2*j] <= node_cnt[l][2*j+1]))
                begin
                    node_cnt[l+1][j] = node_cnt[l][2*j];
                    node_idx[l+1][j] = node_idx[l][2*j];
                    node_ok[l+1][j]  = node_ok[l][2*j];
                end
                else
                begin
                    node_cnt[l+1][j] = node_cnt[l][2*j+1];
                    node_idx[l+1][j] = node_idx[l][2*j+1];
                    node_ok[l+1][j]  = node_ok[l][2*j+1];
                end
            end
        end
    end

    assign victim = node_idx[LEVELS][0];

endmodule

// ===== rtl/core/lfu_frame_table.sv =====
// ----------------------------------------------------------------------------
// lfu_frame_table
// Frame pages, use counts and fill level. Looks up one page, picks the
// frame to use and updates the table when the reference is committed.
// ----------------------------------------------------------------------------
module lfu_frame_table
    import lfu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  page_t         page,
    input  fill_t         active,
    output lfu_decision_t decision
);

    page_t      pages_reg  [FRAMES];
    count_t     counts_reg [FRAMES];
    fill_t      filled_reg;
    fill_t      filled_next;
    fill_t      searched;
    logic [FRAMES-1:0] match;
    logic [FRAMES-1:0] eligible;
    logic       hit_found;
    frame_idx_t hit_slot;
    frame_idx_t victim;
    logic       do_fill;
    frame_idx_t slot;

    // Only filled frames below the active count take part in the lookup
    assign searched = (filled_reg < active) ? filled_reg : active;

    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            match[i]    = (fill_t'(i) < searched) && (pages_reg[i] == page);
            eligible[i] = fill_t'(i) < active;
        end
    end

    // Lowest matching frame is the hit
    always_comb
    begin
        hit_found = 1'b0;
        hit_slot  = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (!hit_found && match[i])
            begin
                hit_found = 1'b1;
                hit_slot  = frame_idx_t'(i);
            end
        end
    end

    lfu_victim_select u_victim (
        .counts   (counts_reg),
        .eligible (eligible),
        .victim   (victim)
    );

    // Choose the frame: hit, next empty frame, or least used
    assign do_fill = !hit_found && (filled_reg < active);

    always_comb
    begin
        priority if (hit_found)
            slot = hit_slot;
        else if (do_fill)
            slot = filled_reg[IDX_BITS-1:0];
        else
            slot = victim;
    end

    assign decision.hit      = hit_found;
    assign decision.evict    = !hit_found && !do_fill;
    assign decision.slot     = slot;
    assign decision.old_page = decision.evict ? pages_reg[slot] : '0;

    assign filled_next = (go && do_fill) ? filled_reg + fill_t'(1) : filled_reg;

    // Advance fill level and use counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            filled_reg <= filled_next;
            if (go)
            begin
                if (hit_found)
                begin
                    if (counts_reg[slot] != COUNT_MAX)
                        counts_reg[slot] <= counts_reg[slot] + COUNT_ONE;
                end
                else
                begin
                    counts_reg[slot] <= COUNT_ONE;
                end
            end
        end
    end

    // Load the page on a miss
    always_ff @(posedge clk)
    begin
        if (go && !hit_found)
            pages_reg[slot] <= page;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(filled_reg) <= FRAMES)
        else $error("fill level beyond frame count");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        go && !decision.hit && !decision.evict |=>
        filled_reg == fill_t'($past(filled_reg) + fill_t'(1)))
        else $error("fill miss did not advance fill level");

endmodule

// ===== rtl/core/lfu_page_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// lfu_page_replacement_unit
// Least-frequently-used page replacement: one page reference in, one
// hit / placement / eviction report out.
// ----------------------------------------------------------------------------
//  channel   signals                               role
//  -------   -----------------------------------   -------------------------
//  in        in_valid, in_stall, page_number       page reference beat
//  out       out_valid, out_stall, hit,            placement report beat
//            frame_index, evicted_valid,
//            evicted_page, fault_count
//  cfg       cfg_wr_en, cfg_wr_data                num_frames register
//
//  One beat per cycle sustained while out is not stalled; each beat passes
//  through an input register, then lookup, minimum search and table update
//  in one pass into the result register.
//  Reset clears fill level, use counts and fault count and sets num_frames
//  to 8; no clearing pass is needed.
//  A stall on out holds the result and backs up into in_stall in the same
//  cycle once the input register is occupied.
// ----------------------------------------------------------------------------
module lfu_page_replacement_unit
    import lfu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_BITS-1:0]      cfg_wr_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [IN_PAGE_BITS-1:0]  page_number,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     hit,
    output logic [OUT_IDX_BITS-1:0]  frame_index,
    output logic                     evicted_valid,
    output logic [OUT_PAGE_BITS-1:0] evicted_page,
    output logic [FAULT_BITS-1:0]    fault_count
);

    logic [CFG_BITS-1:0]   num_frames_reg;
    logic                  in_valid_reg;
    logic                  in_valid_next;
    page_t                 page_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  hit_reg;
    frame_idx_t            slot_reg;
    logic                  evict_reg;
    page_t                 evpage_reg;
    logic [FAULT_BITS-1:0] faults_reg;
    logic [FAULT_BITS-1:0] faults_next;
    logic                  go;
    logic                  in_take;
    lfu_decision_t         decision;

    // Handshake: process the held beat when the result slot frees up
    assign go       = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !go;
    assign in_take  = in_valid && !in_stall;

    assign in_valid_next  = in_take ? 1'b1 : (go ? 1'b0 : in_valid_reg);
    assign out_valid_next = go ? 1'b1 : ((out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg);

    // Saturating fault counter
    assign faults_next = (go && !decision.hit && faults_reg != {FAULT_BITS{1'b1}})
                         ? faults_reg + FAULT_BITS'(1) : faults_reg;

    lfu_frame_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .page     (page_reg),
        .active   (lfu_active(num_frames_reg)),
        .decision (decision)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_frames_reg <= CFG_BITS'(CFG_RESET);
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            faults_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                num_frames_reg <= cfg_wr_data;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            faults_reg    <= faults_next;
        end
    end

    // Capture input beat and result payload
    always_ff @(posedge clk)
    begin
        if (in_take)
            page_reg <= PAGE_BITS'(page_number);
        if (go)
        begin
            hit_reg    <= decision.hit;
            slot_reg   <= decision.slot;
            evict_reg  <= decision.evict;
            evpage_reg <= decision.old_page;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame_index   = OUT_IDX_BITS'(slot_reg);
    assign evicted_valid = evict_reg;
    assign evicted_page  = OUT_PAGE_BITS'(evpage_reg);
    assign fault_count   = faults_reg;

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> out_valid_reg)
        else $error("processed beat left no result");

    a_fault_step: assert property (@(posedge clk) disable iff (!rst_n)
        go && !decision.hit && faults_reg != {FAULT_BITS{1'b1}} |=>
        faults_reg == FAULT_BITS'($past(faults_reg) + FAULT_BITS'(1)))
        else $error("miss did not count a fault");

    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        go && decision.hit |=> $stable(faults_reg))
        else $error("hit changed fault count");

endmodule

// ===== tb/tb_lfu_page_replacement_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lfu_page_replacement_unit
// Self-checking bench for the LFU page replacement unit. A directed table
// covers fill order, hits, tie-breaking eviction and frame count changes
// mid-stream. Random phases follow, each after a new frame count write;
// the last phase runs with no idling on either side. Every output beat is
// checked against the directed table's report or an in-bench model of the frame table.
// ----------------------------------------------------------------------------
module tb_lfu_page_replacement_unit;
    import lfu_pkg::*;

    // One placement report, as seen on the output channel
    typedef struct packed {
        logic                     hit;
        logic [OUT_IDX_BITS-1:0]  frame_index;
        logic                     evicted_valid;
        logic [OUT_PAGE_BITS-1:0] evicted_page;
        logic [FAULT_BITS-1:0]    fault_count;
    } report_t;

    typedef enum logic [0:0] {ROW_REF, ROW_CFG} row_kind_t;

    // One row of the directed table: a page reference or a frame count write
    typedef struct packed {
        row_kind_t   kind;
        logic [15:0] value;
        logic        typed;
        report_t     want;
    } row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [CFG_BITS-1:0]      cfg_wr_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [IN_PAGE_BITS-1:0]  page_number;
    logic                     out_valid;
    logic                     out_stall;
    logic                     hit;
    logic [OUT_IDX_BITS-1:0]  frame_index;
    logic                     evicted_valid;
    logic [OUT_PAGE_BITS-1:0] evicted_page;
    logic [FAULT_BITS-1:0]    fault_count;

    // Shadow copy of the frame table
    page_t               shadow_pages [FRAMES];
    count_t              shadow_uses [FRAMES];
    int                  shadow_filled;
    logic [FAULT_BITS-1:0] shadow_faults;
    logic [CFG_BITS-1:0] shadow_frames;

    report_t pending_reports [$];
    int      mismatches;
    bit      idle_mode;

    lfu_page_replacement_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page_number   (page_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Look up one page, update the shadow table and return the report
    function automatic report_t place_page(input page_t pg);
        report_t rep;
        int      active;
        int      searched;
        int      slot;
        bit      found;
        active   = (shadow_frames == '0) ? 1 :
                   (int'(shadow_frames) > FRAMES) ? FRAMES : int'(shadow_frames);
        searched = (shadow_filled < active) ? shadow_filled : active;
        found    = 1'b0;
        slot     = 0;
        rep      = '0;
        for (int i = 0; i < searched; i++)
        begin
            if (!found && shadow_pages[i] == pg)
            begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found)
        begin
            if (shadow_uses[slot] != COUNT_MAX)
                shadow_uses[slot] = shadow_uses[slot] + 1'b1;
        end
        else
        begin
            if (shadow_filled < active)
            begin
                slot          = shadow_filled;
                shadow_filled = shadow_filled + 1;
            end
            else
            begin
                // Smallest count wins, lowest index on a tie
                slot = 0;
                for (int i = 1; i < active; i++)
                begin
                    if (shadow_uses[i] < shadow_uses[slot])
                        slot = i;
                end
                rep.evicted_valid = 1'b1;
                rep.evicted_page  = OUT_PAGE_BITS'(shadow_pages[slot]);
            end
            shadow_pages[slot] = pg;
            shadow_uses[slot]  = COUNT_ONE;
            if (shadow_faults != '1)
                shadow_faults = shadow_faults + 1'b1;
        end
        rep.hit         = found;
        rep.frame_index = OUT_IDX_BITS'(slot);
        rep.fault_count = shadow_faults;
        return rep;
    endfunction

    // Present one page beat, hold it until taken, then maybe leave a gap
    task automatic send_page(input page_t pg, input logic typed, input report_t want);
        report_t predicted;
        @(negedge clk);
        in_valid    = 1'b1;
        page_number = pg;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = place_page(pg);
        pending_reports.push_back(typed ? want : predicted);
        if (idle_mode && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
    endtask

    // Drain the block, then write the frame count register
    task automatic write_frames(input logic [CFG_BITS-1:0] frames);
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = frames;
        @(posedge clk);
        shadow_frames = frames;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // Random output stall in bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_mode && $urandom_range(0, 5) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(0, 3)) @(negedge clk);
                @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // Check each output beat against the oldest expected report
    always @(posedge clk)
    begin : check_reports
        report_t got;
        report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {hit, frame_index, evicted_valid, evicted_page, fault_count};
            if (pending_reports.size() == 0)
            begin
                if (mismatches < 10)
                    $display("[%0t] unexpected report: hit=%0d idx=%0d ev=%0d evpg=%h fc=%0d",
                             $realtime, got.hit, got.frame_index, got.evicted_valid,
                             got.evicted_page, got.fault_count);
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got.hit !== want.hit || got.frame_index !== want.frame_index ||
                    got.evicted_valid !== want.evicted_valid ||
                    got.evicted_page !== want.evicted_page ||
                    got.fault_count !== want.fault_count)
                begin
                    if (mismatches < 10)
                    begin
                        $display("[%0t] mismatch: exp hit=%0d idx=%0d ev=%0d evpg=%h fc=%0d",
                                 $realtime, want.hit, want.frame_index, want.evicted_valid,
                                 want.evicted_page, want.fault_count);
                        $display("[%0t]           got hit=%0d idx=%0d ev=%0d evpg=%h fc=%0d",
                                 $realtime, got.hit, got.frame_index, got.evicted_valid,
                                 got.evicted_page, got.fault_count);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : stimulus
        row_t        directed_rows [$];
        page_t       pool [12];
        int          pool_n;
        page_t       pg;
        logic [CFG_BITS-1:0] phase_frames [7];

        // Hold everything at known values through reset
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        page_number = '0;
        idle_mode   = 1'b1;
        mismatches  = 0;
        for (int i = 0; i < FRAMES; i++)
        begin
            shadow_pages[i] = '0;
            shadow_uses[i]  = '0;
        end
        shadow_filled = 0;
        shadow_faults = '0;
        shadow_frames = CFG_BITS'(CFG_RESET);
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed table:      kind     value     typed hit idx ev  evicted   faults
        directed_rows.push_back({ROW_CFG, 16'd2,    1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 16'd0});
        directed_rows.push_back({ROW_REF, 16'h0000, 1'b1, 1'b0, 3'd0, 1'b0, 16'h0000, 16'd1});
        directed_rows.push_back({ROW_REF, 16'hFFFF, 1'b1, 1'b0, 3'd1, 1'b0, 16'h0000, 16'd2});
        directed_rows.push_back({ROW_REF, 16'h0000, 1'b1, 1'b1, 3'd0, 1'b0, 16'h0000, 16'd2});
        // full at two frames: frame 1 has the smaller count
        directed_rows.push_back({ROW_REF, 16'h8000, 1'b1, 1'b0, 3'd1, 1'b1, 16'hFFFF, 16'd3});
        // raise the count mid-stream: misses fill the remaining frames in order
        directed_rows.push_back({ROW_CFG, 16'd8,    1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 16'd0});
        directed_rows.push_back({ROW_REF, 16'h0001, 1'b1, 1'b0, 3'd2, 1'b0, 16'h0000, 16'd4});
        directed_rows.push_back({ROW_REF, 16'hFFFF, 1'b1, 1'b0, 3'd3, 1'b0, 16'h0000, 16'd5});
        directed_rows.push_back({ROW_REF, 16'h5555, 1'b1, 1'b0, 3'd4, 1'b0, 16'h0000, 16'd6});
        directed_rows.push_back({ROW_REF, 16'hAAAA, 1'b1, 1'b0, 3'd5, 1'b0, 16'h0000, 16'd7});
        directed_rows.push_back({ROW_REF, 16'h7FFF, 1'b1, 1'b0, 3'd6, 1'b0, 16'h0000, 16'd8});
        directed_rows.push_back({ROW_REF, 16'h1234, 1'b1, 1'b0, 3'd7, 1'b0, 16'h0000, 16'd9});
        // seven frames tie at count 1: lowest index goes
        directed_rows.push_back({ROW_REF, 16'h4321, 1'b1, 1'b0, 3'd1, 1'b1, 16'h8000, 16'd10});
        // zero frames acts as one; frame 2 holding the page is ignored
        directed_rows.push_back({ROW_CFG, 16'd0,    1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 16'd0});
        directed_rows.push_back({ROW_REF, 16'h0000, 1'b1, 1'b1, 3'd0, 1'b0, 16'h0000, 16'd10});
        directed_rows.push_back({ROW_REF, 16'h0001, 1'b1, 1'b0, 3'd0, 1'b1, 16'h0000, 16'd11});
        // above the built count acts as eight; duplicate page hits the lower frame
        directed_rows.push_back({ROW_CFG, 16'd15,   1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 16'd0});
        directed_rows.push_back({ROW_REF, 16'h0001, 1'b1, 1'b1, 3'd0, 1'b0, 16'h0000, 16'd11});
        directed_rows.push_back({ROW_REF, 16'h5555, 1'b1, 1'b1, 3'd4, 1'b0, 16'h0000, 16'd11});
        // shrink to three: frames above keep their pages but drop out
        directed_rows.push_back({ROW_CFG, 16'd3,    1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 16'd0});
        directed_rows.push_back({ROW_REF, 16'hFFFF, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 16'd0});
        directed_rows.push_back({ROW_REF, 16'h0001, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 16'd0});
        directed_rows.push_back({ROW_CFG, 16'd8,    1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 16'd0});
        directed_rows.push_back({ROW_REF, 16'hFFFF, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 16'd0});
        directed_rows.push_back({ROW_REF, 16'hAAAA, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 16'd0});
        directed_rows.push_back({ROW_REF, 16'hC3C3, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 16'd0});

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
                write_frames(directed_rows[r].value[CFG_BITS-1:0]);
            else
                send_page(directed_rows[r].value, directed_rows[r].typed,
                          directed_rows[r].want);
        end

        // Random phases, each after a new frame count write; the last one runs flat out
        phase_frames[0] = 4'd1;
        phase_frames[1] = 4'd8;
        phase_frames[2] = 4'd0;
        phase_frames[3] = 4'd15;
        phase_frames[4] = 4'd2;
        phase_frames[5] = CFG_BITS'($urandom_range(0, 15));
        phase_frames[6] = CFG_BITS'($urandom_range(0, 15));
        for (int p = 0; p < 7; p++)
        begin
            idle_mode = (p != 6);
            write_frames(phase_frames[p]);
            // a small page pool keeps hits frequent; the rest is any page
            for (int k = 0; k < 12; k++)
                pool[k] = page_t'($urandom);
            pool[0] = '0;
            pool[1] = '1;
            pool_n  = $urandom_range(2, 12);
            repeat (210)
            begin
                if ($urandom_range(0, 9) < 7)
                    pg = pool[$urandom_range(0, pool_n - 1)];
                else
                    pg = page_t'($urandom);
                send_page(pg, 1'b0, '0);
            end
        end

        // Drain and let any stray beat show up
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/lfu_pkg.sv
rtl/core/lfu_victim_select.sv
rtl/core/lfu_frame_table.sv
rtl/core/lfu_page_replacement_unit.sv
tb/tb_lfu_page_replacement_unit.sv
